// File: hdl/srcf_pkg.sv
// ----------------------------------------------------------------------------
// srcf_pkg
// shared types, constants and the glyph ramp of the spike removal cross filter
// ----------------------------------------------------------------------------
`default_nettype none

package srcf_pkg;

  localparam int unsigned MaxWidth    = 64;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned MinDim      = 2;
  localparam int unsigned LevelW      = 4;
  localparam int unsigned GlyphW      = 8;
  localparam int unsigned ColW        = $clog2(MaxWidth);
  localparam int unsigned WidthRegW   = 7;
  localparam int unsigned HeightRegW  = 13;
  localparam int unsigned RowW        = HeightRegW;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_CALC = 1'b1
  } srcf_state_e;

  // center pixel and its four neighbours, with presence flags
  typedef struct packed {
    logic [LevelW-1:0] cur;
    logic [LevelW-1:0] up;
    logic [LevelW-1:0] left;
    logic [LevelW-1:0] right;
    logic [LevelW-1:0] down;
    logic              up_ok;
    logic              left_ok;
    logic              right_ok;
    logic              down_ok;
  } nbr_t;

  // ramp " .':~*=@%#", saturating above 9
  function automatic logic [GlyphW-1:0] glyph_of(input logic [LevelW-1:0] lvl);
    logic [GlyphW-1:0] g;
    case (lvl)
      4'd0:    g = 8'h20;
      4'd1:    g = 8'h2E;
      4'd2:    g = 8'h27;
      4'd3:    g = 8'h3A;
      4'd4:    g = 8'h7E;
      4'd5:    g = 8'h2A;
      4'd6:    g = 8'h3D;
      4'd7:    g = 8'h40;
      4'd8:    g = 8'h25;
      default: g = 8'h23;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: hdl/srcf_spike_calc.sv
// ----------------------------------------------------------------------------
// srcf_spike_calc
// spike test against the four neighbours and replacement by their mean
// ----------------------------------------------------------------------------
`default_nettype none

module srcf_spike_calc (
  input  srcf_pkg::nbr_t                      nbr_i,
  output logic [srcf_pkg::LevelW-1:0]         fixed_level_o
);
  import srcf_pkg::*;

  localparam int unsigned SumW = LevelW + 2;
  localparam int unsigned CmpW = LevelW + 1;
  localparam int unsigned ProdW = SumW + 6;

  logic [LevelW-1:0] up_m, left_m, right_m, down_m;
  logic [2:0]        cnt;
  logic [SumW-1:0]   sum;
  logic [ProdW-1:0]  prod3;
  logic [SumW-1:0]   mean;
  logic              spike;

  // missing neighbours count as zero
  assign up_m    = nbr_i.up_ok    ? nbr_i.up    : '0;
  assign left_m  = nbr_i.left_ok  ? nbr_i.left  : '0;
  assign right_m = nbr_i.right_ok ? nbr_i.right : '0;
  assign down_m  = nbr_i.down_ok  ? nbr_i.down  : '0;

  assign cnt = 3'(nbr_i.up_ok) + 3'(nbr_i.left_ok) + 3'(nbr_i.right_ok)
             + 3'(nbr_i.down_ok);

  assign sum = SumW'(up_m) + SumW'(left_m) + SumW'(right_m) + SumW'(down_m);

  // cur - x > 1  <=>  cur >= x + 2
  assign spike = (CmpW'(nbr_i.cur) >= CmpW'(up_m)    + CmpW'(2))
              && (CmpW'(nbr_i.cur) >= CmpW'(left_m)  + CmpW'(2))
              && (CmpW'(nbr_i.cur) >= CmpW'(right_m) + CmpW'(2))
              && (CmpW'(nbr_i.cur) >= CmpW'(down_m)  + CmpW'(2));

  // divide by three: x * 43 / 128, exact for x below 128
  assign prod3 = ProdW'(sum) * ProdW'(43);

  always_comb begin
    case (cnt)
      3'd1:    mean = sum;
      3'd2:    mean = sum >> 1;
      3'd3:    mean = SumW'(prod3[ProdW-1:7]);
      3'd4:    mean = sum >> 2;
      default: mean = SumW'(nbr_i.cur);
    endcase
  end

  assign fixed_level_o = (spike && cnt != 3'd0) ? mean[LevelW-1:0] : nbr_i.cur;

endmodule

`default_nettype wire

// File: hdl/spike_removal_cross_filter_unit.sv
// ----------------------------------------------------------------------------
// spike_removal_cross_filter_unit
// in-place four-neighbour spike removal on a raster stream, one row of latency
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata level, tuser drain
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata level+glyph,
//                                                     tlast row end, tuser frame end
//  apb       in         psel/penable/pwrite, pready=1 image_width @0, image_height @4
//
//  an item of the first row is written to the original row memory in the
//  accept cycle. every other item is accepted in ST_IDLE, which issues the
//  reads of both row memories, and is then computed in ST_CALC, which writes
//  back and loads the output register; no new item is taken in ST_CALC.
//  the compute cycle holds while the output register is full and not taken.
//  items that do not match the expected kind (pixel vs drain) are taken and
//  dropped. reset clears counters and flags; the row memories are not
//  cleared, every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_removal_cross_filter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [3:0] level, [7:4] zero
  input  logic                             s_axis_tuser,   // [0] drain
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,   // [3:0] fixed_level,
                                                           // [11:4] glyph, [15:12] zero
  output logic                             m_axis_tlast,   // row_end
  output logic                             m_axis_tuser,   // [0] frame_end
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srcf_pkg::ApbAddrW-1:0]    paddr,
  input  logic [srcf_pkg::ApbDataW-1:0]    pwdata,
  output logic [srcf_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);
  import srcf_pkg::*;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [WidthRegW-1:0]  image_width_q;
  logic [HeightRegW-1:0] image_height_q;
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WidthRegW'(30);
      image_height_q <= HeightRegW'(20);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  image_width_q  <= pwdata[WidthRegW-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= pwdata[HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = ApbDataW'(image_width_q);
      REG_IMAGE_HEIGHT: prdata = ApbDataW'(image_height_q);
      default:          prdata = '0;
    endcase
  end

  // clamped frame size
  logic [WidthRegW-1:0]  used_w;
  logic [HeightRegW-1:0] used_h;

  always_comb begin
    if (image_width_q < WidthRegW'(MinDim))        used_w = WidthRegW'(MinDim);
    else if (image_width_q > WidthRegW'(MaxWidth)) used_w = WidthRegW'(MaxWidth);
    else                                           used_w = image_width_q;
    if (image_height_q < HeightRegW'(MinDim))         used_h = HeightRegW'(MinDim);
    else if (image_height_q > HeightRegW'(MaxHeight)) used_h = HeightRegW'(MaxHeight);
    else                                              used_h = image_height_q;
  end

  // ---------------------------------------------------------------------------
  // position counters and control
  // ---------------------------------------------------------------------------
  srcf_state_e        state_q, state_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [LevelW-1:0]  left_q, left_d;

  // item latched for the compute cycle
  logic [LevelW-1:0]  lvl_q;
  logic               drain_q, last_q, up_ok_q;
  logic [ColW-1:0]    ccol_q;

  logic [LevelW-1:0]  in_level;
  logic               in_drain;
  logic               accept, last, drain_row, match, first_row;
  logic               issue_rd, calc_done;

  logic               orig_we;
  logic [ColW-1:0]    orig_waddr;
  logic [LevelW-1:0]  orig_wdata;

  logic               out_valid_q, out_valid_d;
  logic [LevelW-1:0]  out_level_q;
  logic [GlyphW-1:0]  out_glyph_q;
  logic               out_row_end_q, out_frame_end_q;

  logic [LevelW-1:0]  cur_q, right_q, up_q;
  logic [LevelW-1:0]  fixed_level;
  nbr_t               nbr;

  assign in_level  = s_axis_tdata[LevelW-1:0];
  assign in_drain  = s_axis_tuser;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // a column at or past the last one counts as the last
  assign last      = (WidthRegW'(col_q) + WidthRegW'(1)) >= used_w;
  assign drain_row = row_q >= used_h;
  assign match     = (in_drain == drain_row);
  assign first_row = !in_drain && (row_q == '0);

  // compute cycle finishes once the output register can take the result
  assign calc_done = (state_q == ST_CALC) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    left_d     = left_q;
    issue_rd   = 1'b0;
    orig_we    = 1'b0;
    orig_waddr = col_q;
    orig_wdata = in_level;
    case (state_q)
      ST_IDLE: begin
        if (accept && match) begin
          if (first_row) begin
            // first row only fills the original row memory
            orig_we = 1'b1;
            if (last) begin
              col_d  = '0;
              left_d = '0;
              row_d  = row_q + RowW'(1);
            end else begin
              col_d = col_q + ColW'(1);
            end
          end else begin
            issue_rd = 1'b1;
            state_d  = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (calc_done) begin
          state_d    = ST_IDLE;
          orig_we    = !drain_q;
          orig_waddr = ccol_q;
          orig_wdata = lvl_q;
          left_d     = fixed_level;
          if (last_q) begin
            col_d  = '0;
            left_d = '0;
            row_d  = drain_q ? '0 : row_q + RowW'(1);
          end else begin
            col_d = col_q + ColW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_rd) begin
      lvl_q   <= in_level;
      drain_q <= in_drain;
      last_q  <= last;
      ccol_q  <= col_q;
      up_ok_q <= in_drain || (row_q >= RowW'(2));
    end
  end

  // ---------------------------------------------------------------------------
  // row memories: original levels (two read ports) and fixed levels
  // ---------------------------------------------------------------------------
  logic [LevelW-1:0] orig_mem [MaxWidth];
  logic [LevelW-1:0] fix_mem  [MaxWidth];

  // right neighbour address wraps past column 63; on the last column it is not used
  always_ff @(posedge clk_i) begin
    if (orig_we) begin
      orig_mem[orig_waddr] <= orig_wdata;
    end
    if (issue_rd) begin
      cur_q   <= orig_mem[col_q];
      right_q <= orig_mem[col_q + ColW'(1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (calc_done) begin
      fix_mem[ccol_q] <= fixed_level;
    end
    if (issue_rd) begin
      up_q <= fix_mem[col_q];
    end
  end

  // ---------------------------------------------------------------------------
  // spike test
  // ---------------------------------------------------------------------------
  always_comb begin
    nbr.cur      = cur_q;
    nbr.up       = up_q;
    nbr.left     = left_q;
    nbr.right    = right_q;
    nbr.down     = lvl_q;
    nbr.up_ok    = up_ok_q;
    nbr.left_ok  = (ccol_q != '0);
    nbr.right_ok = !last_q;
    nbr.down_ok  = !drain_q;
  end

  srcf_spike_calc u_calc (
    .nbr_i         (nbr),
    .fixed_level_o (fixed_level)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (calc_done)     out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (calc_done) begin
      out_level_q     <= fixed_level;
      out_glyph_q     <= glyph_of(fixed_level);
      out_row_end_q   <= last_q;
      out_frame_end_q <= last_q && drain_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_glyph_q, out_level_q};
  assign m_axis_tlast  = out_row_end_q;
  assign m_axis_tuser  = out_frame_end_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // a result only appears after a compute cycle
  a_out_from_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_CALC))
    else $error("result appeared without a compute cycle");

  // read data and latched item hold while the compute cycle stalls
  a_calc_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) && $past(state_q == ST_CALC)
      |-> $stable(cur_q) && $stable(up_q) && $stable(right_q) && $stable(ccol_q))
    else $error("compute operands changed during a stall");

  // row counter never passes MaxHeight, the highest possible drain row
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= RowW'(MaxHeight))
    else $error("row counter out of range");

  // the last drain item sets frame end together with row end
  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_done && drain_q && last_q |=> m_axis_tvalid && m_axis_tuser && m_axis_tlast)
    else $error("frame end lost");
`endif

endmodule

`default_nettype wire
